FILE: hdl/pcbe_pkg.sv
// Shared constants and types of the piecewise cubic Bezier evaluator.
// Depends on nothing; every other file of the block imports it.
package pcbe_pkg;

    localparam int PT_PER_SEG  = 4;
    localparam int PT_IDX_W    = 2;
    localparam int SEG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Operation tag that travels with every queued beat.
    typedef struct packed {
        logic                is_eval;
        logic [PT_IDX_W-1:0] point;
    } pcbe_op_t;

endpackage

FILE: hdl/pcbe_queue.sv
// Short register queue that decouples the front end from the evaluation pipeline.
// Depends on pcbe_pkg for its depth.
module pcbe_queue
    import pcbe_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/pcbe_front.sv
// Front end: takes command beats, clamps t, picks the segment and local t,
// and drops loads aimed beyond the table. Depends on pcbe_pkg.
module pcbe_front
    import pcbe_pkg::*;
#(
    parameter int SEGMENT_COUNT = 8,
    parameter int COORD_BITS    = 16,
    parameter int T_FRAC_BITS   = 16,
    parameter int SEG_W         = 3
)
(
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic                         kind,
    input  logic [T_FRAC_BITS:0]         t_position,
    input  logic [SEG_IDX_W-1:0]         segment_index,
    input  logic [PT_IDX_W-1:0]          point_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         q_valid,
    input  logic                         q_ready,
    output pcbe_op_t                     q_op,
    output logic [SEG_W-1:0]             q_seg,
    output logic [T_FRAC_BITS:0]         q_lt,
    output logic [3*COORD_BITS-1:0]      q_coords
);

    localparam int F    = T_FRAC_BITS;
    localparam int TS_W = F + 1 + SEG_W;
    localparam logic [F:0]     T_ONE   = {1'b1, {F{1'b0}}};
    localparam logic [SEG_W:0] SEG_MAX = (SEG_W + 1)'(SEGMENT_COUNT - 1);

    logic [F:0]         t_clamped;
    logic [TS_W-1:0]    t_scaled;
    logic [TS_W-1:0]    t_scaled_m1;
    logic [SEG_W:0]     seg_raw;
    logic [SEG_W-1:0]   eval_seg;
    logic [TS_W-1:0]    lt_wide;
    logic [4:0]         load_seg_ext;
    logic               load_in_range;
    logic               keep;

    always_comb
    begin
        t_clamped   = (t_position > T_ONE) ? T_ONE : t_position;
        t_scaled    = TS_W'(t_clamped) * TS_W'(SEGMENT_COUNT);
        t_scaled_m1 = t_scaled - 1'b1;
        seg_raw     = t_scaled_m1[TS_W-1:F];
        if (t_clamped == '0)
        begin
            eval_seg = '0;
        end
        else if (seg_raw > SEG_MAX)
        begin
            eval_seg = SEG_MAX[SEG_W-1:0];
        end
        else
        begin
            eval_seg = seg_raw[SEG_W-1:0];
        end
        lt_wide = t_scaled - (TS_W'(eval_seg) << F);

        load_seg_ext  = {2'b00, segment_index};
        load_in_range = (load_seg_ext < 5'(SEGMENT_COUNT));
        keep          = (kind == KIND_EVAL) || load_in_range;
    end

    assign cmd_ready    = q_ready;
    assign q_valid      = cmd_valid && keep;
    assign q_op.is_eval = (kind == KIND_EVAL);
    assign q_op.point   = point_index;
    assign q_seg        = (kind == KIND_EVAL) ? eval_seg : load_seg_ext[SEG_W-1:0];
    assign q_lt         = (kind == KIND_EVAL) ? lt_wide[F:0] : '0;
    assign q_coords     = {coord_x, coord_y, coord_z};

endmodule

FILE: hdl/pcbe_back.sv
// Back end: control point banks and the Bernstein evaluation pipeline with
// its output register. Depends on pcbe_pkg.
module pcbe_back
    import pcbe_pkg::*;
#(
    parameter int SEGMENT_COUNT = 8,
    parameter int COORD_BITS    = 16,
    parameter int T_FRAC_BITS   = 16,
    parameter int SEG_W         = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  pcbe_op_t                     q_op,
    input  logic [SEG_W-1:0]             q_seg,
    input  logic [T_FRAC_BITS:0]         q_lt,
    input  logic [3*COORD_BITS-1:0]      q_coords,
    output logic                         pos_valid,
    input  logic                         pos_ready,
    output logic signed [COORD_BITS-1:0] pos_x,
    output logic signed [COORD_BITS-1:0] pos_y,
    output logic signed [COORD_BITS-1:0] pos_z
);

    localparam int F      = T_FRAC_BITS;
    localparam int CB     = COORD_BITS;
    localparam int W_W    = F + 2;
    localparam int PROD_W = CB + F + 3;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FL_W   = SUM_W - F;
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [FL_W-1:0] SAT_HI = {{(FL_W - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
    localparam logic signed [FL_W-1:0] SAT_LO = {{(FL_W - CB + 1){1'b1}}, {(CB - 1){1'b0}}};

    logic advance;
    logic pop;
    logic wr_en;

    // One bank per control point index, so all four points of a segment
    // are read in the same cycle.
    logic [3*CB-1:0] bank_mem [PT_PER_SEG][SEGMENT_COUNT];
    logic [3*CB-1:0] rd_reg   [PT_PER_SEG];

    logic            v1_reg, v2_reg, v3_reg;
    logic [F:0]      u1_reg, lt1_reg, uu1_reg, tt1_reg;
    logic [F:0]      u0;
    logic [2*F+1:0]  uu_full, tt_full;
    logic [2*F+1:0]  p_full [PT_PER_SEG];
    logic [W_W-1:0]  w_next [PT_PER_SEG];
    logic [W_W-1:0]  w2_reg [PT_PER_SEG];
    logic [3*CB-1:0] c2_reg [PT_PER_SEG];
    logic signed [PROD_W-1:0] prod_next [3][PT_PER_SEG];
    logic signed [PROD_W-1:0] prod3_reg [3][PT_PER_SEG];
    logic signed [SUM_W-1:0]  sum_next  [3];
    logic signed [FL_W-1:0]   fl_next   [3];
    logic signed [CB-1:0]     pos_next  [3];
    logic signed [CB-1:0]     pos_reg   [3];
    logic                     pos_valid_reg;

    assign advance = !pos_valid_reg || pos_ready;
    assign q_ready = advance;
    assign pop     = q_valid && advance;
    assign wr_en   = pop && !q_op.is_eval;

    for (genvar k = 0; k < PT_PER_SEG; k++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            if (wr_en && (q_op.point == PT_IDX_W'(k)))
            begin
                bank_mem[k][q_seg] <= q_coords;
            end
            if (advance)
            begin
                rd_reg[k] <= bank_mem[k][q_seg];
            end
        end
    end

    always_comb
    begin
        u0      = T_ONE - q_lt;
        uu_full = (2*F+2)'(u0) * (2*F+2)'(u0);
        tt_full = (2*F+2)'(q_lt) * (2*F+2)'(q_lt);

        p_full[0] = (2*F+2)'(uu1_reg) * (2*F+2)'(u1_reg);
        p_full[1] = (2*F+2)'(uu1_reg) * (2*F+2)'(lt1_reg);
        p_full[2] = (2*F+2)'(u1_reg)  * (2*F+2)'(tt1_reg);
        p_full[3] = (2*F+2)'(tt1_reg) * (2*F+2)'(lt1_reg);
        w_next[0] = W_W'(p_full[0][2*F:F]);
        w_next[1] = W_W'(p_full[1][2*F:F]) + (W_W'(p_full[1][2*F:F]) << 1);
        w_next[2] = W_W'(p_full[2][2*F:F]) + (W_W'(p_full[2][2*F:F]) << 1);
        w_next[3] = W_W'(p_full[3][2*F:F]);

        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < PT_PER_SEG; k++)
            begin
                prod_next[c][k] = PROD_W'($signed(c2_reg[k][3*CB-1-c*CB -: CB])
                                          * $signed({1'b0, w2_reg[k]}));
            end
            sum_next[c] = SUM_W'(prod3_reg[c][0]) + SUM_W'(prod3_reg[c][1])
                        + SUM_W'(prod3_reg[c][2]) + SUM_W'(prod3_reg[c][3]);
            fl_next[c]  = sum_next[c][SUM_W-1:F];
            if (fl_next[c] > SAT_HI)
            begin
                pos_next[c] = SAT_HI[CB-1:0];
            end
            else if (fl_next[c] < SAT_LO)
            begin
                pos_next[c] = SAT_LO[CB-1:0];
            end
            else
            begin
                pos_next[c] = fl_next[c][CB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u1_reg  <= u0;
            lt1_reg <= q_lt;
            uu1_reg <= uu_full[2*F:F];
            tt1_reg <= tt_full[2*F:F];
            for (int k = 0; k < PT_PER_SEG; k++)
            begin
                w2_reg[k] <= w_next[k];
                c2_reg[k] <= rd_reg[k];
            end
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < PT_PER_SEG; k++)
                begin
                    prod3_reg[c][k] <= prod_next[c][k];
                end
                pos_reg[c] <= pos_next[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            pos_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= pop && q_op.is_eval;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            pos_valid_reg <= v3_reg;
        end
    end

    assign pos_valid = pos_valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];

endmodule

FILE: hdl/piecewise_cubic_bezier_eval.sv
// Top level of the piecewise cubic Bezier spline evaluator.
// Depends on pcbe_pkg, pcbe_front, pcbe_queue and pcbe_back.

// A command beat either loads one control point (kind low) or evaluates the
// spline at a global t (kind high); only evaluations give a result beat,
// carrying the curve point in signed fixed point, floored and saturated.
// The block takes one command beat per clock cycle for as long as the
// result side keeps pos_ready high, whatever the mix of loads and
// evaluations. A result passes first through the four-entry queue, then
// the bank read together with the squares of u and t, the Bernstein
// weight products, the coordinate products and the final sum, floor and
// saturate into the output register. The pipeline stalls as a whole while
// a result waits; the queue lets up to four further command beats in
// meanwhile. The control point table comes up undefined after reset and
// needs no clearing: each point must be loaded before any evaluation in
// its segment. Loads and evaluations are handled strictly in order, so
// an evaluation sees every load accepted before it. Loads addressed past
// the last segment are accepted and ignored.
module piecewise_cubic_bezier_eval
    import pcbe_pkg::*;
#(
    parameter int SEGMENT_COUNT = 8,
    parameter int COORD_BITS    = 16,
    parameter int T_FRAC_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic                         kind,
    input  logic [T_FRAC_BITS:0]         t_position,
    input  logic [SEG_IDX_W-1:0]         segment_index,
    input  logic [PT_IDX_W-1:0]          point_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         pos_valid,
    input  logic                         pos_ready,
    output logic signed [COORD_BITS-1:0] pos_x,
    output logic signed [COORD_BITS-1:0] pos_y,
    output logic signed [COORD_BITS-1:0] pos_z
);

    // Bits needed to address one segment of the table.
    localparam int SEG_W   = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int ENTRY_W = $bits(pcbe_op_t) + SEG_W + T_FRAC_BITS + 1 + 3 * COORD_BITS;

    logic                      f_valid, f_ready;
    pcbe_op_t                  f_op;
    logic [SEG_W-1:0]          f_seg;
    logic [T_FRAC_BITS:0]      f_lt;
    logic [3*COORD_BITS-1:0]   f_coords;

    logic                      b_valid, b_ready;
    logic [ENTRY_W-1:0]        b_data;
    pcbe_op_t                  b_op;
    logic [SEG_W-1:0]          b_seg;
    logic [T_FRAC_BITS:0]      b_lt;
    logic [3*COORD_BITS-1:0]   b_coords;

    pcbe_front #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .COORD_BITS    (COORD_BITS),
        .T_FRAC_BITS   (T_FRAC_BITS),
        .SEG_W         (SEG_W)
    ) u_front (
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .kind          (kind),
        .t_position    (t_position),
        .segment_index (segment_index),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_op          (f_op),
        .q_seg         (f_seg),
        .q_lt          (f_lt),
        .q_coords      (f_coords)
    );

    pcbe_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_op, f_seg, f_lt, f_coords}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_op, b_seg, b_lt, b_coords} = b_data;

    pcbe_back #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .COORD_BITS    (COORD_BITS),
        .T_FRAC_BITS   (T_FRAC_BITS),
        .SEG_W         (SEG_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_op      (b_op),
        .q_seg     (b_seg),
        .q_lt      (b_lt),
        .q_coords  (b_coords),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z)
    );

endmodule

FILE: tb/piecewise_cubic_bezier_eval_checker.sv
`timescale 1ns / 1ps
// Checker for the piecewise cubic Bezier evaluator: mirrors the control point table,
// computes the curve point of every evaluate beat and compares it with the result beats.
// Depends on pcbe_pkg.
module piecewise_cubic_bezier_eval_checker
    import pcbe_pkg::*;
#(
    parameter int SEGMENT_COUNT = 8,
    parameter int COORD_BITS    = 16,
    parameter int T_FRAC_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  logic                         cmd_ready,
    input  logic                         kind,
    input  logic [T_FRAC_BITS:0]         t_position,
    input  logic [SEG_IDX_W-1:0]         segment_index,
    input  logic [PT_IDX_W-1:0]          point_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         pos_valid,
    input  logic                         pos_ready,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    output int                           mismatches,
    output int                           pending,
    output int                           compared
);

    localparam int     DEPTH     = SEGMENT_COUNT * PT_PER_SEG;
    localparam longint ONE       = longint'(1) << T_FRAC_BITS;
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int     REPORT_MAX = 10;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    point_t ctrl_pts [DEPTH];
    point_t pending_points [$];
    int     err_cnt;
    int     cmp_cnt;

    // Drops the fraction towards minus infinity and clamps to the coordinate range.
    function automatic coord_t floor_clamp(input longint acc);
        longint r;
        r = acc >>> T_FRAC_BITS;
        if (r > COORD_MAX) r = COORD_MAX;
        if (r < COORD_MIN) r = COORD_MIN;
        return coord_t'(r);
    endfunction

    function automatic point_t bezier_point(input logic [T_FRAC_BITS:0] t_in);
        longint t;
        longint ts;
        longint seg;
        longint lt;
        longint u;
        longint uu;
        longint tt;
        longint w [PT_PER_SEG];
        longint sx;
        longint sy;
        longint sz;
        int     base;
        int     k;
        point_t p;
        point_t r;
        t = longint'(t_in);
        if (t > ONE) t = ONE;
        seg = 0;
        lt  = 0;
        if (t != 0) begin
            ts  = t * SEGMENT_COUNT;
            seg = (ts - 1) >>> T_FRAC_BITS;
            if (seg >= SEGMENT_COUNT) seg = SEGMENT_COUNT - 1;
            lt  = ts - seg * ONE;
        end
        u    = ONE - lt;
        uu   = (u * u) >>> T_FRAC_BITS;
        tt   = (lt * lt) >>> T_FRAC_BITS;
        w[0] = (uu * u) >>> T_FRAC_BITS;
        w[1] = 3 * ((uu * lt) >>> T_FRAC_BITS);
        w[2] = 3 * ((u * tt) >>> T_FRAC_BITS);
        w[3] = (tt * lt) >>> T_FRAC_BITS;
        base = int'(seg) * PT_PER_SEG;
        sx = 0;
        sy = 0;
        sz = 0;
        for (k = 0; k < PT_PER_SEG; k++)
        begin
            p  = ctrl_pts[base + k];
            sx += longint'($signed(p.x)) * w[k];
            sy += longint'($signed(p.y)) * w[k];
            sz += longint'($signed(p.z)) * w[k];
        end
        r.x = floor_clamp(sx);
        r.y = floor_clamp(sy);
        r.z = floor_clamp(sz);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        point_t want;
        point_t got;
        int     idx;
        if (!rst_n)
        begin
            pending_points.delete();
            err_cnt    = 0;
            cmp_cnt    = 0;
            mismatches <= 0;
            pending    <= 0;
            compared   <= 0;
        end
        else
        begin
            if (pos_valid && pos_ready)
            begin
                got = '{pos_x, pos_y, pos_z};
                if (pending_points.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("%0t: result beat (%0d,%0d,%0d) with no point expected",
                                 $realtime, $signed(got.x), $signed(got.y), $signed(got.z));
                end
                else
                begin
                    want = pending_points.pop_front();
                    cmp_cnt++;
                    if (got !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX)
                            $display("%0t: point mismatch, expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                     $realtime, $signed(want.x), $signed(want.y),
                                     $signed(want.z), $signed(got.x), $signed(got.y),
                                     $signed(got.z));
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                if (kind == KIND_LOAD)
                begin
                    if (int'(segment_index) < SEGMENT_COUNT)
                    begin
                        idx = int'(segment_index) * PT_PER_SEG + int'(point_index);
                        ctrl_pts[idx] = '{coord_x, coord_y, coord_z};
                    end
                end
                else
                    pending_points.push_back(bezier_point(t_position));
            end
            mismatches <= err_cnt;
            pending    <= pending_points.size();
            compared   <= cmp_cnt;
        end
    end

endmodule

FILE: tb/piecewise_cubic_bezier_eval_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the piecewise cubic Bezier evaluator: clock, reset, command
// and result beat stimulus, watchdog and verdict. Depends on pcbe_pkg, the block and
// piecewise_cubic_bezier_eval_checker.
module piecewise_cubic_bezier_eval_tb;
    import pcbe_pkg::*;

    localparam int     SEGMENT_COUNT  = 8;
    localparam int     COORD_BITS     = 16;
    localparam int     T_FRAC_BITS    = 16;
    localparam int     ONE            = 1 << T_FRAC_BITS;
    localparam int     SEG_SPAN       = ONE / SEGMENT_COUNT;
    localparam int     DEPTH          = SEGMENT_COUNT * PT_PER_SEG;
    localparam int     RANDOM_ITEMS   = 400;
    localparam int     DRAIN_CYCLES   = 16;
    localparam int     WATCHDOG_LIMIT = 1000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cmd_valid     = 1'b0;
    logic                   cmd_ready;
    logic                   kind          = KIND_LOAD;
    logic [T_FRAC_BITS:0]   t_position    = '0;
    logic [SEG_IDX_W-1:0]   segment_index = '0;
    logic [PT_IDX_W-1:0]    point_index   = '0;
    coord_t                 coord_x       = '0;
    coord_t                 coord_y       = '0;
    coord_t                 coord_z       = '0;
    logic                   pos_valid;
    logic                   pos_ready     = 1'b0;
    coord_t                 pos_x;
    coord_t                 pos_y;
    coord_t                 pos_z;

    int                     mismatches;
    int                     pending;
    int                     compared;

    // Idle chances in percent; the stimulus process changes them between phases.
    int                     send_idle_pct = 26;
    int                     recv_idle_pct = 45;
    int                     quiet_cycles  = 0;
    int                     load_cnt      = 0;
    int                     eval_cnt      = 0;

    // Which table entries the stimulus has loaded. An evaluation is only ever aimed at a
    // segment whose four points are all loaded, since unloaded entries are undefined.
    logic [DEPTH-1:0]       written       = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    piecewise_cubic_bezier_eval #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .COORD_BITS    (COORD_BITS),
        .T_FRAC_BITS   (T_FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .kind          (kind),
        .t_position    (t_position),
        .segment_index (segment_index),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .pos_valid     (pos_valid),
        .pos_ready     (pos_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z)
    );

    piecewise_cubic_bezier_eval_checker #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .COORD_BITS    (COORD_BITS),
        .T_FRAC_BITS   (T_FRAC_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .kind          (kind),
        .t_position    (t_position),
        .segment_index (segment_index),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .pos_valid     (pos_valid),
        .pos_ready     (pos_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .mismatches    (mismatches),
        .pending       (pending),
        .compared      (compared)
    );

    // The result side takes a fresh decision every cycle, so stalls land on every
    // stage of the pipeline and on every fill level of the command queue.
    always @(posedge clk)
        pos_ready <= ($urandom_range(99) >= recv_idle_pct);

    // The watchdog counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (pos_valid && pos_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Presents one command beat and holds it until it is accepted. A gap drops valid
    // beforehand; otherwise valid stays high straight on from the previous beat, with
    // only the payload changing, so valid gets a single assignment per edge.
    task automatic send_beat(input logic k, input logic [T_FRAC_BITS:0] t,
                             input logic [SEG_IDX_W-1:0] seg,
                             input logic [PT_IDX_W-1:0] pt,
                             input coord_t x, input coord_t y, input coord_t z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        kind          <= k;
        t_position    <= t;
        segment_index <= seg;
        point_index   <= pt;
        coord_x       <= x;
        coord_y       <= y;
        coord_z       <= z;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        if (k == KIND_LOAD)
        begin
            written[int'(seg) * PT_PER_SEG + int'(pt)] = 1'b1;
            load_cnt++;
        end
        else
            eval_cnt++;
    endtask

    // A load carries a random t, which the block must disregard.
    task automatic load_point(input int seg, input int pt,
                              input int x, input int y, input int z);
        send_beat(KIND_LOAD, (T_FRAC_BITS + 1)'($urandom), SEG_IDX_W'(seg),
                  PT_IDX_W'(pt), coord_t'(x), coord_t'(y), coord_t'(z));
    endtask

    // An evaluation carries random point fields, which the block must disregard.
    task automatic eval_at(input int t);
        send_beat(KIND_EVAL, (T_FRAC_BITS + 1)'(t), SEG_IDX_W'($urandom),
                  PT_IDX_W'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
    endtask

    // Picks a t inside a fully loaded segment, leaning on its boundaries. Segment 0
    // owns t = 0 as well, and the last segment also owns every t past 1.0.
    function automatic int random_t();
        int s;
        int t;
        do
            s = $urandom_range(SEGMENT_COUNT - 1);
        while (written[s * PT_PER_SEG +: PT_PER_SEG] != {PT_PER_SEG{1'b1}});
        case ($urandom_range(9))
            0:       t = (s == 0) ? 0 : s * SEG_SPAN + 1;
            1:       t = (s + 1) * SEG_SPAN;
            default: t = (s == 0) ? $urandom_range(SEG_SPAN)
                                  : $urandom_range((s + 1) * SEG_SPAN, s * SEG_SPAN + 1);
        endcase
        if (s == SEGMENT_COUNT - 1 && $urandom_range(7) == 0)
            t = $urandom_range(2 * ONE - 1, ONE + 1);
        return t;
    endfunction

    // Random mix of loads to any entry and evaluations in loaded segments. Later loads
    // overwrite points that evaluations already rely on, so the ordering of loads
    // against evaluations in flight is exercised as well.
    task automatic random_items(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 40)
                load_point($urandom_range(SEGMENT_COUNT - 1), $urandom_range(PT_PER_SEG - 1),
                           $urandom, $urandom, $urandom);
            else
                eval_at(random_t());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Segments 0 and the last one are loaded with coordinate extremes and
        // segment 1 with some small values, then evaluated at t = 0, at both edges of the
        // first segment boundary, at exactly 1.0 and at values past 1.0 that must saturate.
        load_point(0, 0, -32768, 32767, 0);
        load_point(0, 1, 32767, -32768, -1);
        load_point(0, 2, -32768, -32768, 32767);
        load_point(0, 3, 32767, 32767, -32768);
        load_point(1, 0, 32767, 32767, -32768);
        load_point(1, 1, 256, -256, 1);
        load_point(1, 2, -1, 1, -256);
        load_point(1, 3, 0, 0, 0);
        load_point(7, 0, -32768, -32768, -32768);
        load_point(7, 1, -32768, 32767, -32768);
        load_point(7, 2, 32767, -32768, -32768);
        load_point(7, 3, -32768, -32768, 32767);
        eval_at(0);
        eval_at(1);
        eval_at(SEG_SPAN / 2);
        eval_at(SEG_SPAN);
        eval_at(SEG_SPAN + 1);
        eval_at(2 * SEG_SPAN);
        eval_at(ONE - SEG_SPAN + 1);
        eval_at(ONE - 1);
        eval_at(ONE);
        eval_at(ONE + 1);
        eval_at(2 * ONE - 1);

        // Random part in three idling phases: sender lightly idle with the receiver
        // stalling often, then the reverse, then both sides at full rate.
        random_items(RANDOM_ITEMS / 3);
        send_idle_pct <= 45;
        recv_idle_pct <= 26;
        random_items(RANDOM_ITEMS / 3);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d control point loads and %0d spline evaluations,",
                 load_cnt, eval_cnt);
        $display("with %0d curve points checked and %0d mismatches.", compared, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
hdl/pcbe_pkg.sv
hdl/pcbe_queue.sv
hdl/pcbe_front.sv
hdl/pcbe_back.sv
hdl/piecewise_cubic_bezier_eval.sv
tb/piecewise_cubic_bezier_eval_checker.sv
tb/piecewise_cubic_bezier_eval_tb.sv
